[src/opdec_pkg.sv]
// ----------------------------------------------------------------------------
// opdec_pkg
// Shared types, codes and the opcode table for the 6502 opcode predecoder.
// ----------------------------------------------------------------------------
package opdec_pkg;

  localparam int OpW   = 8;
  localparam int AddrW = 16;
  localparam int FlagW = 4;
  localparam int MnW   = 6;
  localparam int ModeW = 4;
  localparam int LenW  = 2;

  // addressing modes
  localparam logic [ModeW-1:0] MODE_IMP = 4'd0;
  localparam logic [ModeW-1:0] MODE_ACC = 4'd1;
  localparam logic [ModeW-1:0] MODE_IMM = 4'd2;
  localparam logic [ModeW-1:0] MODE_ZP  = 4'd3;
  localparam logic [ModeW-1:0] MODE_ZPX = 4'd4;
  localparam logic [ModeW-1:0] MODE_ZPY = 4'd5;
  localparam logic [ModeW-1:0] MODE_IZX = 4'd6;
  localparam logic [ModeW-1:0] MODE_IZY = 4'd7;
  localparam logic [ModeW-1:0] MODE_ABS = 4'd8;
  localparam logic [ModeW-1:0] MODE_ABX = 4'd9;
  localparam logic [ModeW-1:0] MODE_ABY = 4'd10;
  localparam logic [ModeW-1:0] MODE_IND = 4'd11;
  localparam logic [ModeW-1:0] MODE_REL = 4'd12;

  // mnemonics, alphabetical
  localparam logic [MnW-1:0] MN_ADC = 6'd0;
  localparam logic [MnW-1:0] MN_AND = 6'd1;
  localparam logic [MnW-1:0] MN_ASL = 6'd2;
  localparam logic [MnW-1:0] MN_BCC = 6'd3;
  localparam logic [MnW-1:0] MN_BCS = 6'd4;
  localparam logic [MnW-1:0] MN_BEQ = 6'd5;
  localparam logic [MnW-1:0] MN_BIT = 6'd6;
  localparam logic [MnW-1:0] MN_BMI = 6'd7;
  localparam logic [MnW-1:0] MN_BNE = 6'd8;
  localparam logic [MnW-1:0] MN_BPL = 6'd9;
  localparam logic [MnW-1:0] MN_BRK = 6'd10;
  localparam logic [MnW-1:0] MN_BVC = 6'd11;
  localparam logic [MnW-1:0] MN_BVS = 6'd12;
  localparam logic [MnW-1:0] MN_CLC = 6'd13;
  localparam logic [MnW-1:0] MN_CLD = 6'd14;
  localparam logic [MnW-1:0] MN_CLI = 6'd15;
  localparam logic [MnW-1:0] MN_CLV = 6'd16;
  localparam logic [MnW-1:0] MN_CMP = 6'd17;
  localparam logic [MnW-1:0] MN_CPX = 6'd18;
  localparam logic [MnW-1:0] MN_CPY = 6'd19;
  localparam logic [MnW-1:0] MN_DEC = 6'd20;
  localparam logic [MnW-1:0] MN_DEX = 6'd21;
  localparam logic [MnW-1:0] MN_DEY = 6'd22;
  localparam logic [MnW-1:0] MN_EOR = 6'd23;
  localparam logic [MnW-1:0] MN_INC = 6'd24;
  localparam logic [MnW-1:0] MN_INX = 6'd25;
  localparam logic [MnW-1:0] MN_INY = 6'd26;
  localparam logic [MnW-1:0] MN_JMP = 6'd27;
  localparam logic [MnW-1:0] MN_JSR = 6'd28;
  localparam logic [MnW-1:0] MN_LDA = 6'd29;
  localparam logic [MnW-1:0] MN_LDX = 6'd30;
  localparam logic [MnW-1:0] MN_LDY = 6'd31;
  localparam logic [MnW-1:0] MN_LSR = 6'd32;
  localparam logic [MnW-1:0] MN_NOP = 6'd33;
  localparam logic [MnW-1:0] MN_ORA = 6'd34;
  localparam logic [MnW-1:0] MN_PHA = 6'd35;
  localparam logic [MnW-1:0] MN_PHP = 6'd36;
  localparam logic [MnW-1:0] MN_PLA = 6'd37;
  localparam logic [MnW-1:0] MN_PLP = 6'd38;
  localparam logic [MnW-1:0] MN_ROL = 6'd39;
  localparam logic [MnW-1:0] MN_ROR = 6'd40;
  localparam logic [MnW-1:0] MN_RTI = 6'd41;
  localparam logic [MnW-1:0] MN_RTS = 6'd42;
  localparam logic [MnW-1:0] MN_SBC = 6'd43;
  localparam logic [MnW-1:0] MN_SEC = 6'd44;
  localparam logic [MnW-1:0] MN_SED = 6'd45;
  localparam logic [MnW-1:0] MN_SEI = 6'd46;
  localparam logic [MnW-1:0] MN_STA = 6'd47;
  localparam logic [MnW-1:0] MN_STX = 6'd48;
  localparam logic [MnW-1:0] MN_STY = 6'd49;
  localparam logic [MnW-1:0] MN_TAX = 6'd50;
  localparam logic [MnW-1:0] MN_TAY = 6'd51;
  localparam logic [MnW-1:0] MN_TSX = 6'd52;
  localparam logic [MnW-1:0] MN_TXA = 6'd53;
  localparam logic [MnW-1:0] MN_TXS = 6'd54;
  localparam logic [MnW-1:0] MN_TYA = 6'd55;

  // branch flag select, taken from opcode bits 7..6
  localparam logic [1:0] BSEL_N = 2'd0;
  localparam logic [1:0] BSEL_V = 2'd1;
  localparam logic [1:0] BSEL_C = 2'd2;
  localparam logic [1:0] BSEL_Z = 2'd3;

  typedef struct packed {
    logic             known;
    logic [MnW-1:0]   mnemonic;
    logic [ModeW-1:0] mode;
  } opdec_entry_t;

  function automatic opdec_entry_t op_lookup(input logic [OpW-1:0] op);
    opdec_entry_t d;
    d = '{1'b0, MN_ADC, MODE_IMP};
    case (op)
      8'h00: d = '{1'b1, MN_BRK, MODE_IMP};  8'h01: d = '{1'b1, MN_ORA, MODE_IZX};
      8'h05: d = '{1'b1, MN_ORA, MODE_ZP };  8'h06: d = '{1'b1, MN_ASL, MODE_ZP };
      8'h08: d = '{1'b1, MN_PHP, MODE_IMP};  8'h09: d = '{1'b1, MN_ORA, MODE_IMM};
      8'h0A: d = '{1'b1, MN_ASL, MODE_ACC};  8'h0D: d = '{1'b1, MN_ORA, MODE_ABS};
      8'h0E: d = '{1'b1, MN_ASL, MODE_ABS};  8'h10: d = '{1'b1, MN_BPL, MODE_REL};
      8'h11: d = '{1'b1, MN_ORA, MODE_IZY};  8'h15: d = '{1'b1, MN_ORA, MODE_ZPX};
      8'h16: d = '{1'b1, MN_ASL, MODE_ZPX};  8'h18: d = '{1'b1, MN_CLC, MODE_IMP};
      8'h19: d = '{1'b1, MN_ORA, MODE_ABY};  8'h1D: d = '{1'b1, MN_ORA, MODE_ABX};
      8'h1E: d = '{1'b1, MN_ASL, MODE_ABX};  8'h20: d = '{1'b1, MN_JSR, MODE_ABS};
      8'h21: d = '{1'b1, MN_AND, MODE_IZX};  8'h24: d = '{1'b1, MN_BIT, MODE_ZP };
      8'h25: d = '{1'b1, MN_AND, MODE_ZP };  8'h26: d = '{1'b1, MN_ROL, MODE_ZP };
      8'h28: d = '{1'b1, MN_PLP, MODE_IMP};  8'h29: d = '{1'b1, MN_AND, MODE_IMM};
      8'h2A: d = '{1'b1, MN_ROL, MODE_ACC};  8'h2C: d = '{1'b1, MN_BIT, MODE_ABS};
      8'h2D: d = '{1'b1, MN_AND, MODE_ABS};  8'h2E: d = '{1'b1, MN_ROL, MODE_ABS};
      8'h30: d = '{1'b1, MN_BMI, MODE_REL};  8'h31: d = '{1'b1, MN_AND, MODE_IZY};
      8'h35: d = '{1'b1, MN_AND, MODE_ZPX};  8'h36: d = '{1'b1, MN_ROL, MODE_ZPX};
      8'h38: d = '{1'b1, MN_SEC, MODE_IMP};  8'h39: d = '{1'b1, MN_AND, MODE_ABY};
      8'h3D: d = '{1'b1, MN_AND, MODE_ABX};  8'h3E: d = '{1'b1, MN_ROL, MODE_ABX};
      8'h40: d = '{1'b1, MN_RTI, MODE_IMP};  8'h41: d = '{1'b1, MN_EOR, MODE_IZX};
      8'h45: d = '{1'b1, MN_EOR, MODE_ZP };  8'h46: d = '{1'b1, MN_LSR, MODE_ZP };
      8'h48: d = '{1'b1, MN_PHA, MODE_IMP};  8'h49: d = '{1'b1, MN_EOR, MODE_IMM};
      8'h4A: d = '{1'b1, MN_LSR, MODE_ACC};  8'h4C: d = '{1'b1, MN_JMP, MODE_ABS};
      8'h4D: d = '{1'b1, MN_EOR, MODE_ABS};  8'h4E: d = '{1'b1, MN_LSR, MODE_ABS};
      8'h50: d = '{1'b1, MN_BVC, MODE_REL};  8'h51: d = '{1'b1, MN_EOR, MODE_IZY};
      8'h55: d = '{1'b1, MN_EOR, MODE_ZPX};  8'h56: d = '{1'b1, MN_LSR, MODE_ZPX};
      8'h58: d = '{1'b1, MN_CLI, MODE_IMP};  8'h59: d = '{1'b1, MN_EOR, MODE_ABY};
      8'h5D: d = '{1'b1, MN_EOR, MODE_ABX};  8'h5E: d = '{1'b1, MN_LSR, MODE_ABX};
      8'h60: d = '{1'b1, MN_RTS, MODE_IMP};  8'h61: d = '{1'b1, MN_ADC, MODE_IZX};
      8'h65: d = '{1'b1, MN_ADC, MODE_ZP };  8'h66: d = '{1'b1, MN_ROR, MODE_ZP };
      8'h68: d = '{1'b1, MN_PLA, MODE_IMP};  8'h69: d = '{1'b1, MN_ADC, MODE_IMM};
      8'h6A: d = '{1'b1, MN_ROR, MODE_ACC};  8'h6C: d = '{1'b1, MN_JMP, MODE_IND};
      8'h6D: d = '{1'b1, MN_ADC, MODE_ABS};  8'h6E: d = '{1'b1, MN_ROR, MODE_ABS};
      8'h70: d = '{1'b1, MN_BVS, MODE_REL};  8'h71: d = '{1'b1, MN_ADC, MODE_IZY};
      8'h75: d = '{1'b1, MN_ADC, MODE_ZPX};  8'h76: d = '{1'b1, MN_ROR, MODE_ZPX};
      8'h78: d = '{1'b1, MN_SEI, MODE_IMP};  8'h79: d = '{1'b1, MN_ADC, MODE_ABY};
      8'h7D: d = '{1'b1, MN_ADC, MODE_ABX};  8'h7E: d = '{1'b1, MN_ROR, MODE_ABX};
      8'h81: d = '{1'b1, MN_STA, MODE_IZX};  8'h84: d = '{1'b1, MN_STY, MODE_ZP };
      8'h85: d = '{1'b1, MN_STA, MODE_ZP };  8'h86: d = '{1'b1, MN_STX, MODE_ZP };
      8'h88: d = '{1'b1, MN_DEY, MODE_IMP};  8'h8A: d = '{1'b1, MN_TXA, MODE_IMP};
      8'h8C: d = '{1'b1, MN_STY, MODE_ABS};  8'h8D: d = '{1'b1, MN_STA, MODE_ABS};
      8'h8E: d = '{1'b1, MN_STX, MODE_ABS};  8'h90: d = '{1'b1, MN_BCC, MODE_REL};
      8'h91: d = '{1'b1, MN_STA, MODE_IZY};  8'h94: d = '{1'b1, MN_STY, MODE_ZPX};
      8'h95: d = '{1'b1, MN_STA, MODE_ZPX};  8'h96: d = '{1'b1, MN_STX, MODE_ZPY};
      8'h98: d = '{1'b1, MN_TYA, MODE_IMP};  8'h99: d = '{1'b1, MN_STA, MODE_ABY};
      8'h9A: d = '{1'b1, MN_TXS, MODE_IMP};  8'h9D: d = '{1'b1, MN_STA, MODE_ABX};
      8'hA0: d = '{1'b1, MN_LDY, MODE_IMM};  8'hA1: d = '{1'b1, MN_LDA, MODE_IZX};
      8'hA2: d = '{1'b1, MN_LDX, MODE_IMM};  8'hA4: d = '{1'b1, MN_LDY, MODE_ZP };
      8'hA5: d = '{1'b1, MN_LDA, MODE_ZP };  8'hA6: d = '{1'b1, MN_LDX, MODE_ZP };
      8'hA8: d = '{1'b1, MN_TAY, MODE_IMP};  8'hA9: d = '{1'b1, MN_LDA, MODE_IMM};
      8'hAA: d = '{1'b1, MN_TAX, MODE_IMP};  8'hAC: d = '{1'b1, MN_LDY, MODE_ABS};
      8'hAD: d = '{1'b1, MN_LDA, MODE_ABS};  8'hAE: d = '{1'b1, MN_LDX, MODE_ABS};
      8'hB0: d = '{1'b1, MN_BCS, MODE_REL};  8'hB1: d = '{1'b1, MN_LDA, MODE_IZY};
      8'hB4: d = '{1'b1, MN_LDY, MODE_ZPX};  8'hB5: d = '{1'b1, MN_LDA, MODE_ZPX};
      8'hB6: d = '{1'b1, MN_LDX, MODE_ZPY};  8'hB8: d = '{1'b1, MN_CLV, MODE_IMP};
      8'hB9: d = '{1'b1, MN_LDA, MODE_ABY};  8'hBA: d = '{1'b1, MN_TSX, MODE_IMP};
      8'hBC: d = '{1'b1, MN_LDY, MODE_ABX};  8'hBD: d = '{1'b1, MN_LDA, MODE_ABX};
      8'hBE: d = '{1'b1, MN_LDX, MODE_ABY};  8'hC0: d = '{1'b1, MN_CPY, MODE_IMM};
      8'hC1: d = '{1'b1, MN_CMP, MODE_IZX};  8'hC4: d = '{1'b1, MN_CPY, MODE_ZP };
      8'hC5: d = '{1'b1, MN_CMP, MODE_ZP };  8'hC6: d = '{1'b1, MN_DEC, MODE_ZP };
      8'hC8: d = '{1'b1, MN_INY, MODE_IMP};  8'hC9: d = '{1'b1, MN_CMP, MODE_IMM};
      8'hCA: d = '{1'b1, MN_DEX, MODE_IMP};  8'hCC: d = '{1'b1, MN_CPY, MODE_ABS};
      8'hCD: d = '{1'b1, MN_CMP, MODE_ABS};  8'hCE: d = '{1'b1, MN_DEC, MODE_ABS};
      8'hD0: d = '{1'b1, MN_BNE, MODE_REL};  8'hD1: d = '{1'b1, MN_CMP, MODE_IZY};
      8'hD5: d = '{1'b1, MN_CMP, MODE_ZPX};  8'hD6: d = '{1'b1, MN_DEC, MODE_ZPX};
      8'hD8: d = '{1'b1, MN_CLD, MODE_IMP};  8'hD9: d = '{1'b1, MN_CMP, MODE_ABY};
      8'hDD: d = '{1'b1, MN_CMP, MODE_ABX};  8'hDE: d = '{1'b1, MN_DEC, MODE_ABX};
      8'hE0: d = '{1'b1, MN_CPX, MODE_IMM};  8'hE1: d = '{1'b1, MN_SBC, MODE_IZX};
      8'hE4: d = '{1'b1, MN_CPX, MODE_ZP };  8'hE5: d = '{1'b1, MN_SBC, MODE_ZP };
      8'hE6: d = '{1'b1, MN_INC, MODE_ZP };  8'hE8: d = '{1'b1, MN_INX, MODE_IMP};
      8'hE9: d = '{1'b1, MN_SBC, MODE_IMM};  8'hEA: d = '{1'b1, MN_NOP, MODE_IMP};
      8'hEC: d = '{1'b1, MN_CPX, MODE_ABS};  8'hED: d = '{1'b1, MN_SBC, MODE_ABS};
      8'hEE: d = '{1'b1, MN_INC, MODE_ABS};  8'hF0: d = '{1'b1, MN_BEQ, MODE_REL};
      8'hF1: d = '{1'b1, MN_SBC, MODE_IZY};  8'hF5: d = '{1'b1, MN_SBC, MODE_ZPX};
      8'hF6: d = '{1'b1, MN_INC, MODE_ZPX};  8'hF8: d = '{1'b1, MN_SED, MODE_IMP};
      8'hF9: d = '{1'b1, MN_SBC, MODE_ABY};  8'hFD: d = '{1'b1, MN_SBC, MODE_ABX};
      8'hFE: d = '{1'b1, MN_INC, MODE_ABX};
      default: d = '{1'b0, MN_ADC, MODE_IMP};
    endcase
    return d;
  endfunction

  function automatic logic [LenW-1:0] mode_length(input logic [ModeW-1:0] mode);
    logic [LenW-1:0] len;
    if (mode == MODE_IMP || mode == MODE_ACC) begin
      len = 2'd1;
    end else if (mode == MODE_ABS || mode == MODE_ABX || mode == MODE_ABY ||
                 mode == MODE_IND) begin
      len = 2'd3;
    end else begin
      len = 2'd2;
    end
    return len;
  endfunction

endpackage

[src/cpu6502_opcode_predecoder.sv]
// ----------------------------------------------------------------------------
// cpu6502_opcode_predecoder
// Three-stage pipelined decoder for official 6502 opcodes and branch targets.
// ----------------------------------------------------------------------------
// Usage:
//   input channel: in_valid / in_stall with opcode, operand_low, operand_high,
//   program_counter and cond_flags. output channel: out_valid / out_stall with
//   known, mnemonic, addr_mode, length, operand_value, branch_target and
//   branch_taken. every input word gives exactly one output word.
//   a word passes through three register stages (table lookup, length and
//   operand select with pc+2, branch target add) from acceptance to out_valid;
//   one word is accepted every cycle while in_stall is low.
//   unknown opcodes give known=0, length 1 and all other fields 0.
//   reset clears the stage valid bits only, so the pipe comes up empty.
//   when out_stall is high the last stage holds its word; each earlier stage
//   keeps moving while it has an empty slot ahead of it, and in_stall rises
//   only once all three stages are full and the output is stalled.
// ----------------------------------------------------------------------------
module cpu6502_opcode_predecoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [opdec_pkg::OpW-1:0]     opcode,
  input  logic [7:0]                    operand_low,
  input  logic [7:0]                    operand_high,
  input  logic [opdec_pkg::AddrW-1:0]   program_counter,
  input  logic [opdec_pkg::FlagW-1:0]   cond_flags,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          known,
  output logic [opdec_pkg::MnW-1:0]     mnemonic,
  output logic [opdec_pkg::ModeW-1:0]   addr_mode,
  output logic [opdec_pkg::LenW-1:0]    length,
  output logic [opdec_pkg::AddrW-1:0]   operand_value,
  output logic [opdec_pkg::AddrW-1:0]   branch_target,
  output logic                          branch_taken
);
  import opdec_pkg::*;

  // stage valids and advance enables
  logic s1_valid, s2_valid, s3_valid;
  logic s1_ready, s2_ready, s3_ready;

  // stage 1: table lookup
  opdec_entry_t     lookup;
  opdec_entry_t     s1_dec;
  logic [2:0]       s1_op_hi;
  logic [7:0]       s1_lo;
  logic [7:0]       s1_hi;
  logic [AddrW-1:0] s1_pc;
  logic [FlagW-1:0] s1_flags;

  // stage 2: length, operand, condition, pc+2
  logic [LenW-1:0]  s2_len_next;
  logic [AddrW-1:0] s2_opval_next;
  logic             s2_is_branch_next;
  logic             s2_cond_bit;
  logic             s2_taken_next;
  opdec_entry_t     s2_dec;
  logic [LenW-1:0]  s2_len;
  logic [AddrW-1:0] s2_opval;
  logic             s2_is_branch;
  logic             s2_taken;
  logic [AddrW-1:0] s2_pc2;
  logic [7:0]       s2_lo;

  logic [AddrW-1:0] target_next;

  assign s3_ready = !s3_valid || !out_stall;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_stall = !s1_ready;
  assign out_valid = s3_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
    end
  end

  assign lookup = op_lookup(opcode);

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_dec   <= lookup;
      s1_op_hi <= opcode[7:5];
      s1_lo    <= operand_low;
      s1_hi    <= operand_high;
      s1_pc    <= program_counter;
      s1_flags <= cond_flags;
    end
  end

  always_comb begin
    s2_len_next = mode_length(s1_dec.mode);
    case (s2_len_next)
      2'd3:    s2_opval_next = {s1_hi, s1_lo};
      2'd2:    s2_opval_next = {8'h00, s1_lo};
      default: s2_opval_next = '0;
    endcase
    s2_is_branch_next = s1_dec.known && (s1_dec.mode == MODE_REL);
    // opcode bits 7..6 pick the flag, bit 5 gives the value that takes the branch
    case (s1_op_hi[2:1])
      BSEL_N:  s2_cond_bit = s1_flags[3];
      BSEL_V:  s2_cond_bit = s1_flags[2];
      BSEL_C:  s2_cond_bit = s1_flags[0];
      BSEL_Z:  s2_cond_bit = s1_flags[1];
      default: s2_cond_bit = 1'b0;
    endcase
    s2_taken_next = s2_is_branch_next && (s2_cond_bit == s1_op_hi[0]);
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_dec       <= s1_dec;
      s2_len       <= s2_len_next;
      s2_opval     <= s2_opval_next;
      s2_is_branch <= s2_is_branch_next;
      s2_taken     <= s2_taken_next;
      s2_pc2       <= s1_pc + AddrW'(2);
      s2_lo        <= s1_lo;
    end
  end

  // sign-extended displacement, wraps at 64k
  assign target_next = s2_is_branch ? (s2_pc2 + {{(AddrW-8){s2_lo[7]}}, s2_lo}) : '0;

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      known         <= s2_dec.known;
      mnemonic      <= s2_dec.mnemonic;
      addr_mode     <= s2_dec.mode;
      length        <= s2_len;
      operand_value <= s2_opval;
      branch_target <= target_next;
      branch_taken  <= s2_taken;
    end
  end

endmodule

[tb/cpu6502_opcode_predecoder_tb.sv]
// ----------------------------------------------------------------------------
// cpu6502_opcode_predecoder_tb
// Self-checking bench for the 6502 opcode predecoder. A short table of
// directed words hits each addressing mode, undefined opcodes, the corrected
// STY zp,X and SED encodings and branch targets that wrap. A shuffled sweep of
// all 256 opcode values follows, then a mix weighted toward official opcodes
// and branches. Each word is checked against a local decode model or a fixed
// decode; the sender idles in bursts, the receiver stalls in changing styles.
// ----------------------------------------------------------------------------
module cpu6502_opcode_predecoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import opdec_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 8;
  localparam int MIXED_WORDS  = 480;

  typedef struct packed {
    logic             known;
    logic [MnW-1:0]   mnemonic;
    logic [ModeW-1:0] mode;
    logic [LenW-1:0]  len;
    logic [AddrW-1:0] operand;
    logic [AddrW-1:0] target;
    logic             taken;
  } decode_t;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [7:0]       lo;
    logic [7:0]       hi;
    logic [AddrW-1:0] pc;
    logic [FlagW-1:0] flags;
    logic             typed;
    decode_t          want;
  } vec_t;

  localparam decode_t NO_DECODE =
    '{1'b0, MN_ADC, MODE_IMP, 2'd1, 16'h0000, 16'h0000, 1'b0};
  // BPL from the top of memory, forward displacement wraps to 0x0080
  localparam decode_t BPL_WRAP =
    '{1'b1, MN_BPL, MODE_REL, 2'd2, 16'h007F, 16'h0080, 1'b1};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  vec_t cur_word = '0;
  logic in_stall;
  logic out_valid;
  logic known;
  logic [MnW-1:0] mnemonic;
  logic [ModeW-1:0] addr_mode;
  logic [LenW-1:0] length;
  logic [AddrW-1:0] operand_value;
  logic [AddrW-1:0] branch_target;
  logic branch_taken;

  // decode model
  bit official[256];
  logic [MnW-1:0] mn_of[256];
  logic [ModeW-1:0] mode_of[256];

  decode_t pending_decodes[$];
  int words_in = 0;
  int errors = 0;
  int n_official = 0;
  int n_undefined = 0;
  int n_branch = 0;
  int n_taken = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int style_left = 0;
  int stall_style = 0;
  int cyc = 0;

  cpu6502_opcode_predecoder i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (cur_word.op),
    .operand_low    (cur_word.lo),
    .operand_high   (cur_word.hi),
    .program_counter(cur_word.pc),
    .cond_flags     (cur_word.flags),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .known          (known),
    .mnemonic       (mnemonic),
    .addr_mode      (addr_mode),
    .length         (length),
    .operand_value  (operand_value),
    .branch_target  (branch_target),
    .branch_taken   (branch_taken)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  function automatic void def_op(input logic [31:0] op, input logic [MnW-1:0] mn,
                                 input logic [ModeW-1:0] md);
    official[op[7:0]] = 1'b1;
    mn_of[op[7:0]] = mn;
    mode_of[op[7:0]] = md;
  endfunction

  initial begin
    for (int i = 0; i < 256; i++) begin
      official[i] = 1'b0;
      mn_of[i] = MN_ADC;
      mode_of[i] = MODE_IMP;
    end
    def_op('h00, MN_BRK, MODE_IMP); def_op('h01, MN_ORA, MODE_IZX); def_op('h05, MN_ORA, MODE_ZP);
    def_op('h06, MN_ASL, MODE_ZP); def_op('h08, MN_PHP, MODE_IMP); def_op('h09, MN_ORA, MODE_IMM);
    def_op('h0A, MN_ASL, MODE_ACC); def_op('h0D, MN_ORA, MODE_ABS); def_op('h0E, MN_ASL, MODE_ABS);
    def_op('h10, MN_BPL, MODE_REL); def_op('h11, MN_ORA, MODE_IZY); def_op('h15, MN_ORA, MODE_ZPX);
    def_op('h16, MN_ASL, MODE_ZPX); def_op('h18, MN_CLC, MODE_IMP); def_op('h19, MN_ORA, MODE_ABY);
    def_op('h1D, MN_ORA, MODE_ABX); def_op('h1E, MN_ASL, MODE_ABX); def_op('h20, MN_JSR, MODE_ABS);
    def_op('h21, MN_AND, MODE_IZX); def_op('h24, MN_BIT, MODE_ZP); def_op('h25, MN_AND, MODE_ZP);
    def_op('h26, MN_ROL, MODE_ZP); def_op('h28, MN_PLP, MODE_IMP); def_op('h29, MN_AND, MODE_IMM);
    def_op('h2A, MN_ROL, MODE_ACC); def_op('h2C, MN_BIT, MODE_ABS); def_op('h2D, MN_AND, MODE_ABS);
    def_op('h2E, MN_ROL, MODE_ABS); def_op('h30, MN_BMI, MODE_REL); def_op('h31, MN_AND, MODE_IZY);
    def_op('h35, MN_AND, MODE_ZPX); def_op('h36, MN_ROL, MODE_ZPX); def_op('h38, MN_SEC, MODE_IMP);
    def_op('h39, MN_AND, MODE_ABY); def_op('h3D, MN_AND, MODE_ABX); def_op('h3E, MN_ROL, MODE_ABX);
    def_op('h40, MN_RTI, MODE_IMP); def_op('h41, MN_EOR, MODE_IZX); def_op('h45, MN_EOR, MODE_ZP);
    def_op('h46, MN_LSR, MODE_ZP); def_op('h48, MN_PHA, MODE_IMP); def_op('h49, MN_EOR, MODE_IMM);
    def_op('h4A, MN_LSR, MODE_ACC); def_op('h4C, MN_JMP, MODE_ABS); def_op('h4D, MN_EOR, MODE_ABS);
    def_op('h4E, MN_LSR, MODE_ABS); def_op('h50, MN_BVC, MODE_REL); def_op('h51, MN_EOR, MODE_IZY);
    def_op('h55, MN_EOR, MODE_ZPX); def_op('h56, MN_LSR, MODE_ZPX); def_op('h58, MN_CLI, MODE_IMP);
    def_op('h59, MN_EOR, MODE_ABY); def_op('h5D, MN_EOR, MODE_ABX); def_op('h5E, MN_LSR, MODE_ABX);
    def_op('h60, MN_RTS, MODE_IMP); def_op('h61, MN_ADC, MODE_IZX); def_op('h65, MN_ADC, MODE_ZP);
    def_op('h66, MN_ROR, MODE_ZP); def_op('h68, MN_PLA, MODE_IMP); def_op('h69, MN_ADC, MODE_IMM);
    def_op('h6A, MN_ROR, MODE_ACC); def_op('h6C, MN_JMP, MODE_IND); def_op('h6D, MN_ADC, MODE_ABS);
    def_op('h6E, MN_ROR, MODE_ABS); def_op('h70, MN_BVS, MODE_REL); def_op('h71, MN_ADC, MODE_IZY);
    def_op('h75, MN_ADC, MODE_ZPX); def_op('h76, MN_ROR, MODE_ZPX); def_op('h78, MN_SEI, MODE_IMP);
    def_op('h79, MN_ADC, MODE_ABY); def_op('h7D, MN_ADC, MODE_ABX); def_op('h7E, MN_ROR, MODE_ABX);
    def_op('h81, MN_STA, MODE_IZX); def_op('h84, MN_STY, MODE_ZP); def_op('h85, MN_STA, MODE_ZP);
    def_op('h86, MN_STX, MODE_ZP); def_op('h88, MN_DEY, MODE_IMP); def_op('h8A, MN_TXA, MODE_IMP);
    def_op('h8C, MN_STY, MODE_ABS); def_op('h8D, MN_STA, MODE_ABS); def_op('h8E, MN_STX, MODE_ABS);
    def_op('h90, MN_BCC, MODE_REL); def_op('h91, MN_STA, MODE_IZY); def_op('h94, MN_STY, MODE_ZPX);
    def_op('h95, MN_STA, MODE_ZPX); def_op('h96, MN_STX, MODE_ZPY); def_op('h98, MN_TYA, MODE_IMP);
    def_op('h99, MN_STA, MODE_ABY); def_op('h9A, MN_TXS, MODE_IMP); def_op('h9D, MN_STA, MODE_ABX);
    def_op('hA0, MN_LDY, MODE_IMM); def_op('hA1, MN_LDA, MODE_IZX); def_op('hA2, MN_LDX, MODE_IMM);
    def_op('hA4, MN_LDY, MODE_ZP); def_op('hA5, MN_LDA, MODE_ZP); def_op('hA6, MN_LDX, MODE_ZP);
    def_op('hA8, MN_TAY, MODE_IMP); def_op('hA9, MN_LDA, MODE_IMM); def_op('hAA, MN_TAX, MODE_IMP);
    def_op('hAC, MN_LDY, MODE_ABS); def_op('hAD, MN_LDA, MODE_ABS); def_op('hAE, MN_LDX, MODE_ABS);
    def_op('hB0, MN_BCS, MODE_REL); def_op('hB1, MN_LDA, MODE_IZY); def_op('hB4, MN_LDY, MODE_ZPX);
    def_op('hB5, MN_LDA, MODE_ZPX); def_op('hB6, MN_LDX, MODE_ZPY); def_op('hB8, MN_CLV, MODE_IMP);
    def_op('hB9, MN_LDA, MODE_ABY); def_op('hBA, MN_TSX, MODE_IMP); def_op('hBC, MN_LDY, MODE_ABX);
    def_op('hBD, MN_LDA, MODE_ABX); def_op('hBE, MN_LDX, MODE_ABY); def_op('hC0, MN_CPY, MODE_IMM);
    def_op('hC1, MN_CMP, MODE_IZX); def_op('hC4, MN_CPY, MODE_ZP); def_op('hC5, MN_CMP, MODE_ZP);
    def_op('hC6, MN_DEC, MODE_ZP); def_op('hC8, MN_INY, MODE_IMP); def_op('hC9, MN_CMP, MODE_IMM);
    def_op('hCA, MN_DEX, MODE_IMP); def_op('hCC, MN_CPY, MODE_ABS); def_op('hCD, MN_CMP, MODE_ABS);
    def_op('hCE, MN_DEC, MODE_ABS); def_op('hD0, MN_BNE, MODE_REL); def_op('hD1, MN_CMP, MODE_IZY);
    def_op('hD5, MN_CMP, MODE_ZPX); def_op('hD6, MN_DEC, MODE_ZPX); def_op('hD8, MN_CLD, MODE_IMP);
    def_op('hD9, MN_CMP, MODE_ABY); def_op('hDD, MN_CMP, MODE_ABX); def_op('hDE, MN_DEC, MODE_ABX);
    def_op('hE0, MN_CPX, MODE_IMM); def_op('hE1, MN_SBC, MODE_IZX); def_op('hE4, MN_CPX, MODE_ZP);
    def_op('hE5, MN_SBC, MODE_ZP); def_op('hE6, MN_INC, MODE_ZP); def_op('hE8, MN_INX, MODE_IMP);
    def_op('hE9, MN_SBC, MODE_IMM); def_op('hEA, MN_NOP, MODE_IMP); def_op('hEC, MN_CPX, MODE_ABS);
    def_op('hED, MN_SBC, MODE_ABS); def_op('hEE, MN_INC, MODE_ABS); def_op('hF0, MN_BEQ, MODE_REL);
    def_op('hF1, MN_SBC, MODE_IZY); def_op('hF5, MN_SBC, MODE_ZPX); def_op('hF6, MN_INC, MODE_ZPX);
    def_op('hF8, MN_SED, MODE_IMP); def_op('hF9, MN_SBC, MODE_ABY); def_op('hFD, MN_SBC, MODE_ABX);
    def_op('hFE, MN_INC, MODE_ABX);
  end

  function automatic decode_t decode_opcode(input vec_t v);
    decode_t d;
    logic [AddrW-1:0] disp;
    logic flag;
    d = NO_DECODE;
    if (official[v.op]) begin
      d.known = 1'b1;
      d.mnemonic = mn_of[v.op];
      d.mode = mode_of[v.op];
      case (d.mode)
        MODE_IMP, MODE_ACC: d.len = 2'd1;
        MODE_ABS, MODE_ABX, MODE_ABY, MODE_IND: d.len = 2'd3;
        default: d.len = 2'd2;
      endcase
      if (d.len == 2'd3) d.operand = {v.hi, v.lo};
      else if (d.len == 2'd2) d.operand = {8'h00, v.lo};
      if (d.mode == MODE_REL) begin
        disp = {{8{v.lo[7]}}, v.lo};
        d.target = v.pc + 16'd2 + disp;
        // opcode bits 7..6 pick the flag, bit 5 is the value that takes the branch
        case (v.op[7:6])
          BSEL_N: flag = v.flags[3];
          BSEL_V: flag = v.flags[2];
          BSEL_C: flag = v.flags[0];
          default: flag = v.flags[1];
        endcase
        d.taken = (flag == v.op[5]);
      end
    end
    return d;
  endfunction

  function automatic vec_t mk(input logic [7:0] op, input logic [7:0] lo, input logic [7:0] hi,
                              input logic [15:0] pc, input logic [3:0] flags,
                              input logic typed, input decode_t want);
    vec_t v;
    v = '{op, lo, hi, pc, flags, typed, want};
    return v;
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(7, 0))
      0: b = 8'h00;
      1: b = 8'hFF;
      2: b = 8'h7F;
      3: b = 8'h80;
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  function automatic vec_t random_word(input logic [7:0] op);
    vec_t v;
    v.op = op;
    v.lo = pick_byte();
    v.hi = pick_byte();
    v.flags = 4'($urandom);
    case ($urandom_range(7, 0))
      0: v.pc = 16'($urandom_range(3, 0));
      1: v.pc = 16'(16'hFFFF - $urandom_range(3, 0));
      default: v.pc = 16'($urandom);
    endcase
    v.typed = 1'b0;
    v.want = NO_DECODE;
    return v;
  endfunction

  task automatic send_word(input vec_t v);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(6, 0);
      burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(80, 40) : $urandom_range(16, 1);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cur_word <= v;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  // output checking first, then capture of the word accepted at this edge
  always @(posedge clk) begin : check_proc
    decode_t got;
    decode_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{known, mnemonic, addr_mode, length, operand_value, branch_target, branch_taken};
        if (pending_decodes.size() == 0) begin
          $display("%0t ns: result word with nothing pending, got 0x%0h", $time, got);
          errors++;
        end else begin
          want = pending_decodes.pop_front();
          check_field("known", 16'(want.known), 16'(got.known));
          check_field("mnemonic", 16'(want.mnemonic), 16'(got.mnemonic));
          check_field("addr_mode", 16'(want.mode), 16'(got.mode));
          check_field("length", 16'(want.len), 16'(got.len));
          check_field("operand_value", want.operand, got.operand);
          check_field("branch_target", want.target, got.target);
          check_field("branch_taken", 16'(want.taken), 16'(got.taken));
          if (want.known) n_official++;
          else n_undefined++;
          if (want.known && want.mode == MODE_REL) begin
            n_branch++;
            if (want.taken) n_taken++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending_decodes.push_back(cur_word.typed ? cur_word.want : decode_opcode(cur_word));
        words_in <= words_in + 1;
      end
    end
  end

  // receiver: one long hold-off once HOLD_AT words are in, otherwise changing stall styles
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (style_left == 0) begin
      stall_style <= $urandom_range(3, 0);
      style_left <= $urandom_range(120, 20);
    end else begin
      style_left <= style_left - 1;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && words_in >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(3, 0) == 0);
        2: out_stall <= ($urandom_range(3, 0) != 0);
        default: out_stall <= (cyc % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    vec_t directed_words[$];
    logic [7:0] order[256];
    logic [7:0] tmp;
    logic [7:0] op;
    logic [2:0] cond;
    int j;
    int pick;
    // undefined opcodes, the first two with every other field at its extremes
    directed_words.push_back(mk(8'h02, 8'hFF, 8'hFF, 16'hFFFF, 4'hF, 1'b1, NO_DECODE));
    directed_words.push_back(mk(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 4'hF, 1'b1, NO_DECODE));
    directed_words.push_back(mk(8'h80, 8'h12, 8'h34, 16'h1234, 4'h0, 1'b1, NO_DECODE));
    // one word per addressing mode
    directed_words.push_back(mk(8'h00, 8'h00, 8'h00, 16'h0000, 4'h0, 1'b0, NO_DECODE));
    directed_words.push_back(mk(8'h0A, 8'hFF, 8'hFF, 16'h8000, 4'hF, 1'b0, NO_DECODE));
    directed_words.push_back(mk(8'hA9, 8'hFF, 8'hFF, 16'hFFFF, 4'h0, 1'b0, NO_DECODE));
    directed_words.push_back(mk(8'hA5, 8'h00, 8'hFF, 16'h0200, 4'h5, 1'b0, NO_DECODE));
    directed_words.push_back(mk(8'hB5, 8'h80, 8'h01, 16'h0300, 4'hA, 1'b0, NO_DECODE));
    directed_words.push_back(mk(8'hB6, 8'h7F, 8'h02, 16'h0400, 4'h3, 1'b0, NO_DECODE));
    directed_words.push_back(mk(8'hA1, 8'h44, 8'h55, 16'h0500, 4'hC, 1'b0, NO_DECODE));
    directed_words.push_back(mk(8'hB1, 8'h66, 8'h77, 16'h0600, 4'h1, 1'b0, NO_DECODE));
    directed_words.push_back(mk(8'hAD, 8'hFF, 8'hFF, 16'hFFFE, 4'h8, 1'b0, NO_DECODE));
    directed_words.push_back(mk(8'hBD, 8'h00, 8'h00, 16'h0001, 4'h2, 1'b0, NO_DECODE));
    directed_words.push_back(mk(8'hB9, 8'h34, 8'h12, 16'hC000, 4'h4, 1'b0, NO_DECODE));
    directed_words.push_back(mk(8'h6C, 8'hFF, 8'h02, 16'hE000, 4'h6, 1'b0, NO_DECODE));
    // corrected encodings: STY zp,X and SED
    directed_words.push_back(mk(8'h94, 8'h10, 8'h20, 16'h1000, 4'h9, 1'b0, NO_DECODE));
    directed_words.push_back(mk(8'hF8, 8'hAB, 8'hCD, 16'h2000, 4'h7, 1'b0, NO_DECODE));
    // all eight branches, targets wrapping at both ends of memory, then INC abs,X
    directed_words.push_back(mk(8'h10, 8'h7F, 8'h00, 16'hFFFF, 4'h0, 1'b1, BPL_WRAP));
    directed_words.push_back(mk(8'h30, 8'h80, 8'hFF, 16'h0000, 4'h8, 1'b0, NO_DECODE));
    directed_words.push_back(mk(8'h50, 8'h00, 8'h00, 16'h1234, 4'h4, 1'b0, NO_DECODE));
    directed_words.push_back(mk(8'h70, 8'hFE, 8'h00, 16'h4000, 4'h4, 1'b0, NO_DECODE));
    directed_words.push_back(mk(8'h90, 8'h01, 8'h00, 16'h5000, 4'h1, 1'b0, NO_DECODE));
    directed_words.push_back(mk(8'hB0, 8'h81, 8'h00, 16'h0010, 4'h1, 1'b0, NO_DECODE));
    directed_words.push_back(mk(8'hD0, 8'h40, 8'h00, 16'hFFC0, 4'h2, 1'b0, NO_DECODE));
    directed_words.push_back(mk(8'hF0, 8'hC0, 8'h00, 16'h0020, 4'hD, 1'b0, NO_DECODE));
    directed_words.push_back(mk(8'hFE, 8'h01, 8'h80, 16'h7FFF, 4'hE, 1'b0, NO_DECODE));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_words[i]) send_word(directed_words[i]);

    // every opcode value once, in random order
    for (int i = 0; i < 256; i++) order[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(i, 0);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < 256; i++) send_word(random_word(order[i]));

    // mostly official opcodes, a good share of branches, some raw bytes
    for (int n = 0; n < MIXED_WORDS; n++) begin
      pick = $urandom_range(99, 0);
      if (pick < 55) begin
        op = 8'($urandom);
        while (!official[op]) op = 8'($urandom);
      end else if (pick < 75) begin
        cond = 3'($urandom_range(7, 0));
        op = {cond, 5'b10000};
      end else begin
        op = 8'($urandom);
      end
      send_word(random_word(op));
    end
    in_valid <= 1'b0;

    // let the last accepted word reach the queue before waiting on it
    @(posedge clk);
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("decoded %0d words: %0d official, %0d undefined, %0d branches (%0d taken)",
             words_in, n_official, n_undefined, n_branch, n_taken);
    $display("all 256 opcode values offered; %0d-cycle output hold-off backed up the input",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[cpu6502_opcode_predecoder.f]
src/opdec_pkg.sv
src/cpu6502_opcode_predecoder.sv
tb/cpu6502_opcode_predecoder_tb.sv
